[hdl/assert_macros.svh]
// Assertion macros for the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define CBM_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("%m: implication failed");

// Next-cycle implication, off while reset is asserted.
`define CBM_ASSERT_NXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

// Next-cycle implication that also holds through reset.
`define CBM_ASSERT_RST(name, clk, ante, cons) \
    name: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("%m: reset check failed");

`endif

[hdl/cbm_pkg.sv]
// Shared types and character codes for the bracket matcher.
`timescale 1ns / 1ps
`default_nettype none
package cbm_pkg;

    localparam int POS_OUT_W = 16;
    localparam int CNT_OUT_W = 7;
    localparam int KIND_W    = 2;

    localparam logic [15:0] CH_CURLY_OPEN  = 16'h007B;
    localparam logic [15:0] CH_ROUND_OPEN  = 16'h0028;
    localparam logic [15:0] CH_SQUARE_OPEN = 16'h005B;
    localparam logic [15:0] CH_CURLY_CLOSE = 16'h007D;
    localparam logic [15:0] CH_ROUND_CLOSE = 16'h0029;
    localparam logic [15:0] CH_SQUARE_CLOSE = 16'h005D;
    localparam logic [15:0] CH_NEWLINE     = 16'h000A;
    localparam logic [15:0] CH_DQUOTE      = 16'h0022;
    localparam logic [15:0] CH_SQUOTE      = 16'h0027;
    localparam logic [15:0] CH_BACKSLASH   = 16'h005C;
    localparam logic [15:0] CH_SLASH       = 16'h002F;
    localparam logic [15:0] CH_STAR        = 16'h002A;

    typedef enum logic [KIND_W-1:0] {
        KIND_CURLY  = 2'd0,
        KIND_ROUND  = 2'd1,
        KIND_SQUARE = 2'd2
    } kind_t;

    // Shift command for the row of stack cells
    typedef struct packed {
        logic push;
        logic pop;
    } stack_op_t;

    typedef struct packed {
        logic                 pair_found;
        logic [POS_OUT_W-1:0] open_position;
        logic [POS_OUT_W-1:0] close_position;
        logic [CNT_OUT_W-1:0] open_curly;
        logic [CNT_OUT_W-1:0] open_round;
        logic                 overflowed;
        logic                 final_res;
    } result_t;

endpackage
`default_nettype wire

[hdl/cbm_stack_cell.sv]
// One entry of the shifting opener stack.
`timescale 1ns / 1ps
`default_nettype none
module cbm_stack_cell #(
    parameter int ENTRY_W = 18
) (
    input  wire logic               aclk,
    input  wire cbm_pkg::stack_op_t op,
    input  wire logic [ENTRY_W-1:0] push_data,
    input  wire logic [ENTRY_W-1:0] pop_data,
    output logic      [ENTRY_W-1:0] entry
);

    logic [ENTRY_W-1:0] entry_reg;
    logic [ENTRY_W-1:0] entry_next;

    // push moves everything one cell deeper, pop pulls it one cell up
    always_comb begin
        entry_next = entry_reg;
        if (op.push) begin
            entry_next = push_data;
        end else if (op.pop) begin
            entry_next = pop_data;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule
`default_nettype wire

[hdl/cbm_lexer.sv]
// Lexer, bracket bookkeeping and stack control for one code unit per cycle while accept is high.
`timescale 1ns / 1ps
`default_nettype none
module cbm_lexer #(
    parameter int STACK_DEPTH   = 64,
    parameter int POSITION_BITS = 16
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  accept,
    input  wire logic [15:0]           code_unit,
    input  wire logic                  end_of_text,
    input  wire logic [POSITION_BITS+cbm_pkg::KIND_W-1:0] top_entry,
    output cbm_pkg::stack_op_t         op,
    output logic [POSITION_BITS+cbm_pkg::KIND_W-1:0] push_entry,
    output cbm_pkg::result_t           result
);

    localparam int ENTRY_W = POSITION_BITS + cbm_pkg::KIND_W;
    localparam int FILL_W  = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W   = POSITION_BITS + 1;

    typedef enum logic [2:0] {
        MODE_CODE,
        MODE_LINE,
        MODE_BLOCK,
        MODE_STR,
        MODE_CHR
    } mode_t;

    mode_t              mode_reg, mode_next;
    logic               pend_reg, pend_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [FILL_W-1:0]  curly_reg, curly_next;
    logic [FILL_W-1:0]  round_reg, round_next;
    logic [IDX_W-1:0]   index_reg, index_next;
    logic               ovf_reg, ovf_next;

    logic               code_path;
    logic               is_open, is_close;
    cbm_pkg::kind_t     kind;
    logic               push_ok, pop_ok;
    logic               pos_over;
    logic               stack_full;
    logic [POSITION_BITS-1:0] pos;

    assign pos        = index_reg[POSITION_BITS-1:0];
    assign pos_over   = index_reg[POSITION_BITS];
    assign stack_full = (fill_reg == FILL_W'(STACK_DEPTH));

    always_comb begin
        mode_next = mode_reg;
        pend_next = pend_reg;
        code_path = 1'b0;
        unique case (mode_reg)
            MODE_CODE: begin
                if (pend_reg) begin
                    pend_next = 1'b0;
                    if (code_unit == cbm_pkg::CH_SLASH) begin
                        mode_next = MODE_LINE;
                    end else if (code_unit == cbm_pkg::CH_STAR) begin
                        mode_next = MODE_BLOCK;
                    end else begin
                        code_path = 1'b1;
                    end
                end else begin
                    code_path = 1'b1;
                end
                if (code_path) begin
                    if (code_unit == cbm_pkg::CH_SLASH) begin
                        pend_next = 1'b1;
                    end else if (code_unit == cbm_pkg::CH_DQUOTE) begin
                        mode_next = MODE_STR;
                    end else if (code_unit == cbm_pkg::CH_SQUOTE) begin
                        mode_next = MODE_CHR;
                    end
                end
            end
            MODE_LINE: begin
                if (code_unit == cbm_pkg::CH_NEWLINE) begin
                    mode_next = MODE_CODE;
                end
            end
            MODE_BLOCK: begin
                if (pend_reg && code_unit == cbm_pkg::CH_SLASH) begin
                    mode_next = MODE_CODE;
                    pend_next = 1'b0;
                end else begin
                    pend_next = (code_unit == cbm_pkg::CH_STAR);
                end
            end
            MODE_STR, MODE_CHR: begin
                if (pend_reg) begin
                    pend_next = 1'b0;
                end else if (code_unit == cbm_pkg::CH_BACKSLASH) begin
                    pend_next = 1'b1;
                end else if ((mode_reg == MODE_STR && code_unit == cbm_pkg::CH_DQUOTE) ||
                             (mode_reg == MODE_CHR && code_unit == cbm_pkg::CH_SQUOTE)) begin
                    mode_next = MODE_CODE;
                end
            end
            default: begin
                mode_next = MODE_CODE;
                pend_next = 1'b0;
            end
        endcase
    end

    // bracket decode, only meaningful on the code path
    always_comb begin
        is_open  = 1'b0;
        is_close = 1'b0;
        kind     = cbm_pkg::KIND_CURLY;
        case (code_unit)
            cbm_pkg::CH_CURLY_OPEN:   begin is_open  = 1'b1; kind = cbm_pkg::KIND_CURLY;  end
            cbm_pkg::CH_ROUND_OPEN:   begin is_open  = 1'b1; kind = cbm_pkg::KIND_ROUND;  end
            cbm_pkg::CH_SQUARE_OPEN:  begin is_open  = 1'b1; kind = cbm_pkg::KIND_SQUARE; end
            cbm_pkg::CH_CURLY_CLOSE:  begin is_close = 1'b1; kind = cbm_pkg::KIND_CURLY;  end
            cbm_pkg::CH_ROUND_CLOSE:  begin is_close = 1'b1; kind = cbm_pkg::KIND_ROUND;  end
            cbm_pkg::CH_SQUARE_CLOSE: begin is_close = 1'b1; kind = cbm_pkg::KIND_SQUARE; end
            default: ;
        endcase
    end

    assign push_ok = code_path && is_open && !stack_full && !pos_over;
    assign pop_ok  = code_path && is_close && (fill_reg != '0) &&
                     (top_entry[ENTRY_W-1 -: cbm_pkg::KIND_W] == kind);

    always_comb begin
        fill_next  = fill_reg;
        curly_next = curly_reg;
        round_next = round_reg;
        ovf_next   = ovf_reg;
        index_next = pos_over ? index_reg : index_reg + IDX_W'(1);
        if (code_path && is_open && !push_ok) begin
            ovf_next = 1'b1;
        end
        if (push_ok) begin
            fill_next = fill_reg + FILL_W'(1);
            if (kind == cbm_pkg::KIND_CURLY) begin
                curly_next = curly_reg + FILL_W'(1);
            end else begin
                round_next = round_reg + FILL_W'(1);
            end
        end
        if (pop_ok) begin
            fill_next = fill_reg - FILL_W'(1);
            if (kind == cbm_pkg::KIND_CURLY) begin
                if (curly_reg != '0) curly_next = curly_reg - FILL_W'(1);
            end else begin
                if (round_reg != '0) round_next = round_reg - FILL_W'(1);
            end
            if (pos_over) begin
                ovf_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_CODE;
            pend_reg  <= 1'b0;
            fill_reg  <= '0;
            curly_reg <= '0;
            round_reg <= '0;
            index_reg <= '0;
            ovf_reg   <= 1'b0;
        end else if (accept) begin
            if (end_of_text) begin
                mode_reg  <= MODE_CODE;
                pend_reg  <= 1'b0;
                fill_reg  <= '0;
                curly_reg <= '0;
                round_reg <= '0;
                index_reg <= '0;
                ovf_reg   <= 1'b0;
            end else begin
                mode_reg  <= mode_next;
                pend_reg  <= pend_next;
                fill_reg  <= fill_next;
                curly_reg <= curly_next;
                round_reg <= round_next;
                index_reg <= index_next;
                ovf_reg   <= ovf_next;
            end
        end
    end

    assign op.push    = accept && push_ok;
    assign op.pop     = accept && pop_ok;
    assign push_entry = {kind, pos};

    always_comb begin
        result.pair_found     = pop_ok && !pos_over;
        result.open_position  = '0;
        result.close_position = '0;
        if (pop_ok && !pos_over) begin
            result.open_position  = cbm_pkg::POS_OUT_W'(top_entry[POSITION_BITS-1:0]);
            result.close_position = cbm_pkg::POS_OUT_W'(pos);
        end
        result.open_curly = (32'(curly_next) > 32'd127) ? 7'd127 :
                            cbm_pkg::CNT_OUT_W'(curly_next);
        result.open_round = (32'(round_next) > 32'd127) ? 7'd127 :
                            cbm_pkg::CNT_OUT_W'(round_next);
        result.overflowed = ovf_next;
        result.final_res  = end_of_text;
    end

endmodule
`default_nettype wire

[hdl/cbm_out_skid.sv]
// Output register with a skid stage for the result channel.
`timescale 1ns / 1ps
`default_nettype none
module cbm_out_skid (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire cbm_pkg::result_t in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output cbm_pkg::result_t      out_data
);

    logic             main_valid_reg;
    logic             skid_valid_reg;
    cbm_pkg::result_t main_reg;
    cbm_pkg::result_t skid_reg;
    logic             take_out;

    assign in_ready = !skid_valid_reg;
    assign take_out = main_valid_reg && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (take_out) begin
                main_reg       <= skid_reg;
                skid_valid_reg <= 1'b0;
            end
        end else if (in_valid) begin
            if (!main_valid_reg || take_out) begin
                main_reg       <= in_data;
                main_valid_reg <= 1'b1;
            end else begin
                skid_reg       <= in_data;
                skid_valid_reg <= 1'b1;
            end
        end else if (take_out) begin
            main_valid_reg <= 1'b0;
        end
    end

    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

endmodule
`default_nettype wire

[hdl/code_bracket_matcher.sv]
// Top level: bracket matcher over a stream of text code units.
//
//  channel | dir | tdata                                  | tuser      | tlast
//  s_      | in  | [15:0] code_unit                       | -          | end_of_text
//  m_      | out | open_pos, close_pos, curly, round, ovf | pair_found | final_res
//
// One code unit per cycle while s_tready is high, one registered result
// per unit. The lexer and stack top decide each unit combinationally;
// the opener stack is a row of cells that shift on push/pop.
// Reset (synchronous, active low) clears lexer state, counts and fill; stack
// cells keep no reset. A two-entry output stage keeps input flowing for one
// beat of output stall; s_tready drops only while both entries are full.
`timescale 1ns / 1ps
`default_nettype none
module code_bracket_matcher #(
    parameter int STACK_DEPTH   = 64,
    parameter int POSITION_BITS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [15:0] code_unit
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [15:0] open_position, [31:16] close_position, [38:32] open_curly,
    // [45:39] open_round, [46] overflowed, [47] zero
    output logic [47:0]      m_tdata,
    output logic             m_tuser,   // [0] pair_found
    output logic             m_tlast
);

    localparam int ENTRY_W = POSITION_BITS + cbm_pkg::KIND_W;

    logic               accept;
    cbm_pkg::stack_op_t op;
    logic [ENTRY_W-1:0] push_entry;
    logic [ENTRY_W-1:0] entries [STACK_DEPTH];
    cbm_pkg::result_t   lex_result;
    cbm_pkg::result_t   out_result;

    assign accept = s_tvalid && s_tready;

    cbm_lexer #(
        .STACK_DEPTH   (STACK_DEPTH),
        .POSITION_BITS (POSITION_BITS)
    ) u_lexer (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .code_unit   (s_tdata),
        .end_of_text (s_tlast),
        .top_entry   (entries[0]),
        .op          (op),
        .push_entry  (push_entry),
        .result      (lex_result)
    );

    for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
        logic [ENTRY_W-1:0] from_above;
        logic [ENTRY_W-1:0] from_below;
        if (i == 0) begin : g_head
            assign from_above = push_entry;
        end else begin : g_body
            assign from_above = entries[i-1];
        end
        if (i == STACK_DEPTH - 1) begin : g_tail
            assign from_below = '0;
        end else begin : g_inner
            assign from_below = entries[i+1];
        end
        cbm_stack_cell #(
            .ENTRY_W (ENTRY_W)
        ) u_cell (
            .aclk      (aclk),
            .op        (op),
            .push_data (from_above),
            .pop_data  (from_below),
            .entry     (entries[i])
        );
    end

    cbm_out_skid u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (lex_result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_result)
    );

    assign m_tdata = {1'b0, out_result.overflowed, out_result.open_round,
                      out_result.open_curly, out_result.close_position,
                      out_result.open_position};
    assign m_tuser = out_result.pair_found;
    assign m_tlast = out_result.final_res;

endmodule
`default_nettype wire

[hdl/cbm_checker.sv]
// Port-level checker for the bracket matcher, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module cbm_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [15:0] s_tdata,
    input wire logic        s_tlast,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [47:0] m_tdata,
    input wire logic        m_tuser,
    input wire logic        m_tlast
);

    `CBM_ASSERT_RST(a_reset_empty, aclk, !aresetn, !m_tvalid && s_tready)
    `CBM_ASSERT_NXT(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
    `CBM_ASSERT_IMP(a_no_pair_zero, aclk, aresetn, m_tvalid && !m_tuser, m_tdata[31:0] == 32'd0)
    `CBM_ASSERT_IMP(a_backpressure, aclk, aresetn, !s_tready, m_tvalid)

endmodule

bind code_bracket_matcher cbm_checker u_cbm_checker (.*);
`default_nettype wire

[bench/code_bracket_matcher_tb.sv]
// Self-checking testbench for the bracket matcher: predicts and checks every result beat.
`timescale 1ns / 1ps
module code_bracket_matcher_tb;

    localparam int STACK_DEPTH   = 64;
    localparam int POSITION_BITS = 16;
    localparam int RANDOM_UNITS  = 1700;
    localparam int CYCLE_LIMIT   = 1_000_000;

    typedef enum logic [2:0] {
        LEX_CODE,
        LEX_LINE_CMT,
        LEX_BLOCK_CMT,
        LEX_STRING,
        LEX_CHAR
    } lex_mode_t;

    class bracket_pair_board_t;
        cbm_pkg::result_t predicted_beats[$];
        int        errors;
        int        checked;
        int        pairs;
        int        overflow_beats;
        lex_mode_t mode;
        bit        pending;  // slash, star or escape, depending on mode
        cbm_pkg::kind_t stack_kind[STACK_DEPTH];
        logic [15:0] stack_pos[STACK_DEPTH];
        int unsigned fill;
        int unsigned curly_open;
        int unsigned round_open;
        logic [POSITION_BITS:0] index;
        bit        lost;

        function new();
            restart();
        endfunction

        function void restart();
            mode       = LEX_CODE;
            pending    = 1'b0;
            fill       = 0;
            curly_open = 0;
            round_open = 0;
            index      = '0;
            lost       = 1'b0;
        endfunction

        function void push_opener(cbm_pkg::kind_t k);
            if (fill >= STACK_DEPTH || index[POSITION_BITS]) begin
                lost = 1'b1;
                return;
            end
            stack_kind[fill] = k;
            stack_pos[fill]  = index[15:0];
            fill++;
            if (k == cbm_pkg::KIND_CURLY) curly_open++;
            else round_open++;
        endfunction

        function void pop_closer(cbm_pkg::kind_t k, inout cbm_pkg::result_t r);
            int unsigned top;
            if (fill == 0 || stack_kind[fill - 1] != k) return;
            top  = fill - 1;
            fill = top;
            if (k == cbm_pkg::KIND_CURLY) begin
                if (curly_open > 0) curly_open--;
            end else begin
                if (round_open > 0) round_open--;
            end
            // a closer past the position range still pops and flags overflow, but reports no pair
            if (index[POSITION_BITS]) begin
                lost = 1'b1;
                return;
            end
            r.pair_found     = 1'b1;
            r.open_position  = stack_pos[top];
            r.close_position = index[15:0];
        endfunction

        function void code_char(logic [15:0] u, inout cbm_pkg::result_t r);
            case (u)
                cbm_pkg::CH_SLASH:        pending = 1'b1;
                cbm_pkg::CH_DQUOTE:       mode = LEX_STRING;
                cbm_pkg::CH_SQUOTE:       mode = LEX_CHAR;
                cbm_pkg::CH_CURLY_OPEN:   push_opener(cbm_pkg::KIND_CURLY);
                cbm_pkg::CH_ROUND_OPEN:   push_opener(cbm_pkg::KIND_ROUND);
                cbm_pkg::CH_SQUARE_OPEN:  push_opener(cbm_pkg::KIND_SQUARE);
                cbm_pkg::CH_CURLY_CLOSE:  pop_closer(cbm_pkg::KIND_CURLY, r);
                cbm_pkg::CH_ROUND_CLOSE:  pop_closer(cbm_pkg::KIND_ROUND, r);
                cbm_pkg::CH_SQUARE_CLOSE: pop_closer(cbm_pkg::KIND_SQUARE, r);
                default: ;
            endcase
        endfunction

        function void note_unit(logic [15:0] u, logic last);
            cbm_pkg::result_t r;
            logic [15:0] quote;
            r = '0;
            case (mode)
                LEX_CODE: begin
                    if (pending) begin
                        pending = 1'b0;
                        if (u == cbm_pkg::CH_SLASH) mode = LEX_LINE_CMT;
                        else if (u == cbm_pkg::CH_STAR) mode = LEX_BLOCK_CMT;
                        else code_char(u, r);
                    end else begin
                        code_char(u, r);
                    end
                end
                LEX_LINE_CMT: begin
                    if (u == cbm_pkg::CH_NEWLINE) mode = LEX_CODE;
                end
                LEX_BLOCK_CMT: begin
                    if (pending && u == cbm_pkg::CH_SLASH) begin
                        mode    = LEX_CODE;
                        pending = 1'b0;
                    end else begin
                        pending = (u == cbm_pkg::CH_STAR);
                    end
                end
                default: begin
                    quote = (mode == LEX_STRING) ? cbm_pkg::CH_DQUOTE : cbm_pkg::CH_SQUOTE;
                    if (pending) pending = 1'b0;
                    else if (u == cbm_pkg::CH_BACKSLASH) pending = 1'b1;
                    else if (u == quote) mode = LEX_CODE;
                end
            endcase
            if (!index[POSITION_BITS]) index++;
            r.open_curly = 7'(curly_open);
            r.open_round = 7'(round_open);
            r.overflowed = lost;
            r.final_res  = last;
            predicted_beats.push_back(r);
            if (last) restart();
        endfunction

        function string show(cbm_pkg::result_t r);
            return $sformatf("pair=%0b open=%0d close=%0d curly=%0d round=%0d ovf=%0b last=%0b",
                             r.pair_found, r.open_position, r.close_position,
                             r.open_curly, r.open_round, r.overflowed, r.final_res);
        endfunction

        function void check_result(cbm_pkg::result_t got);
            cbm_pkg::result_t want;
            if (predicted_beats.size() == 0) begin
                errors++;
                if (errors <= 10) $display("ERROR: unpredicted result beat: %s", show(got));
                return;
            end
            want = predicted_beats.pop_front();
            checked++;
            if (want.pair_found) pairs++;
            if (want.overflowed) overflow_beats++;
            if (got.pair_found !== want.pair_found || got.open_position !== want.open_position
                    || got.close_position !== want.close_position
                    || got.open_curly !== want.open_curly || got.open_round !== want.open_round
                    || got.overflowed !== want.overflowed || got.final_res !== want.final_res) begin
                errors++;
                if (errors <= 10) begin
                    $display("ERROR: beat %0d mismatch", checked);
                    $display("  expected %s", show(want));
                    $display("  actual   %s", show(got));
                end
            end
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    bracket_pair_board_t board = new();
    logic [15:0]    text_q[$];
    cbm_pkg::kind_t nest_q[$];
    bit          gaps_on    = 1'b1;
    int          texts_sent = 0;
    int          units_sent = 0;
    int          cycle_count = 0;

    code_bracket_matcher #(
        .STACK_DEPTH  (STACK_DEPTH),
        .POSITION_BITS(POSITION_BITS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d beats still expected",
                     cycle_count, board.predicted_beats.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic bit is_special(logic [15:0] u);
        case (u)
            cbm_pkg::CH_CURLY_OPEN, cbm_pkg::CH_ROUND_OPEN, cbm_pkg::CH_SQUARE_OPEN,
            cbm_pkg::CH_CURLY_CLOSE, cbm_pkg::CH_ROUND_CLOSE, cbm_pkg::CH_SQUARE_CLOSE,
            cbm_pkg::CH_NEWLINE, cbm_pkg::CH_DQUOTE, cbm_pkg::CH_SQUOTE,
            cbm_pkg::CH_BACKSLASH, cbm_pkg::CH_SLASH, cbm_pkg::CH_STAR: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic [15:0] any_special();
        case ($urandom_range(0, 11))
            0:       return cbm_pkg::CH_CURLY_OPEN;
            1:       return cbm_pkg::CH_ROUND_OPEN;
            2:       return cbm_pkg::CH_SQUARE_OPEN;
            3:       return cbm_pkg::CH_CURLY_CLOSE;
            4:       return cbm_pkg::CH_ROUND_CLOSE;
            5:       return cbm_pkg::CH_SQUARE_CLOSE;
            6:       return cbm_pkg::CH_NEWLINE;
            7:       return cbm_pkg::CH_DQUOTE;
            8:       return cbm_pkg::CH_SQUOTE;
            9:       return cbm_pkg::CH_BACKSLASH;
            10:      return cbm_pkg::CH_SLASH;
            default: return cbm_pkg::CH_STAR;
        endcase
    endfunction

    function automatic logic [15:0] plain_unit();
        logic [15:0] u;
        do u = 16'($urandom_range(0, 65535)); while (is_special(u));
        return u;
    endfunction

    function automatic logic [15:0] opener_of(cbm_pkg::kind_t k);
        case (k)
            cbm_pkg::KIND_CURLY: return cbm_pkg::CH_CURLY_OPEN;
            cbm_pkg::KIND_ROUND: return cbm_pkg::CH_ROUND_OPEN;
            default:             return cbm_pkg::CH_SQUARE_OPEN;
        endcase
    endfunction

    function automatic logic [15:0] closer_of(cbm_pkg::kind_t k);
        case (k)
            cbm_pkg::KIND_CURLY: return cbm_pkg::CH_CURLY_CLOSE;
            cbm_pkg::KIND_ROUND: return cbm_pkg::CH_ROUND_CLOSE;
            default:             return cbm_pkg::CH_SQUARE_CLOSE;
        endcase
    endfunction

    function automatic cbm_pkg::kind_t any_kind();
        return cbm_pkg::kind_t'($urandom_range(0, 2));
    endfunction

    // filler for comment and literal bodies
    function automatic logic [15:0] body_unit();
        case ($urandom_range(0, 3))
            0:       return plain_unit();
            1:       return opener_of(any_kind());
            2:       return closer_of(any_kind());
            default: return any_special();
        endcase
    endfunction

    function automatic void add_str(string s);
        for (int i = 0; i < s.len(); i++) text_q.push_back({8'h00, s[i]});
    endfunction

    // Mostly well-nested code with comments and literals, some noise on top.
    task automatic build_random_text();
        int    target;
        int    n;
        cbm_pkg::kind_t k;
        text_q.delete();
        nest_q.delete();
        if ($urandom_range(0, 14) == 0) begin
            // nest 60 to 70 deep, around the stack depth, then unwind
            n = $urandom_range(60, 70);
            repeat (n) begin
                k = any_kind();
                nest_q.push_back(k);
                text_q.push_back(opener_of(k));
            end
            while (nest_q.size() > 0) text_q.push_back(closer_of(nest_q.pop_back()));
            return;
        end
        target = $urandom_range(1, 60);
        while (text_q.size() < target) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3: text_q.push_back(plain_unit());
                4, 5, 6, 7: begin
                    k = any_kind();
                    nest_q.push_back(k);
                    text_q.push_back(opener_of(k));
                end
                8, 9, 10, 11: begin
                    if (nest_q.size() > 0) text_q.push_back(closer_of(nest_q.pop_back()));
                    else text_q.push_back(closer_of(any_kind()));
                end
                12: begin
                    add_str("//");
                    repeat ($urandom_range(0, 5)) text_q.push_back(body_unit());
                    if ($urandom_range(0, 7) != 0) text_q.push_back(cbm_pkg::CH_NEWLINE);
                end
                13: begin
                    add_str("/*");
                    repeat ($urandom_range(0, 6)) begin
                        case ($urandom_range(0, 3))
                            0:       text_q.push_back(cbm_pkg::CH_STAR);
                            1:       text_q.push_back(cbm_pkg::CH_SLASH);
                            default: text_q.push_back(body_unit());
                        endcase
                    end
                    add_str("*/");
                end
                14: begin
                    text_q.push_back(cbm_pkg::CH_DQUOTE);
                    repeat ($urandom_range(0, 6)) begin
                        if ($urandom_range(0, 3) == 0) text_q.push_back(cbm_pkg::CH_BACKSLASH);
                        text_q.push_back(body_unit());
                    end
                    text_q.push_back(cbm_pkg::CH_DQUOTE);
                end
                15: begin
                    text_q.push_back(cbm_pkg::CH_SQUOTE);
                    if ($urandom_range(0, 1) == 0) begin
                        text_q.push_back(cbm_pkg::CH_BACKSLASH);
                        text_q.push_back(any_special());
                    end else begin
                        text_q.push_back(plain_unit());
                    end
                    text_q.push_back(cbm_pkg::CH_SQUOTE);
                end
                16: begin
                    // slash that turns out to be plain text
                    text_q.push_back(cbm_pkg::CH_SLASH);
                    text_q.push_back($urandom_range(0, 1) ? plain_unit() : opener_of(any_kind()));
                end
                default: text_q.push_back(any_special());
            endcase
        end
        if ($urandom_range(0, 2) != 0) begin
            while (nest_q.size() > 0) text_q.push_back(closer_of(nest_q.pop_back()));
        end
    endtask

    task automatic send_unit(logic [15:0] u, logic last);
        int gap;
        gap = gaps_on ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= u;
        s_tlast  <= last;
        do @(posedge aclk); while (s_tready !== 1'b1);
        board.note_unit(u, last);
        units_sent++;
    endtask

    task automatic send_text();
        foreach (text_q[i]) send_unit(text_q[i], i == text_q.size() - 1);
        texts_sent++;
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (board.predicted_beats.size() != 0);
    endtask

    // result side: random stalls per beat
    initial begin : result_sink
        int               stall;
        cbm_pkg::result_t got;
        forever begin
            stall = gaps_on ? $urandom_range(0, 9) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(aresetn === 1'b1 && m_tvalid === 1'b1));
            got.pair_found     = m_tuser;
            got.open_position  = m_tdata[15:0];
            got.close_position = m_tdata[31:16];
            got.open_curly     = m_tdata[38:32];
            got.open_round     = m_tdata[45:39];
            got.overflowed     = m_tdata[46];
            got.final_res      = m_tlast;
            board.check_result(got);
        end
    end

    initial begin : stimulus
        int random_units;
        random_units = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // all bracket kinds, a mismatched closer, extreme code units
        text_q.delete();
        add_str("{([)]})");
        text_q.push_back(16'hFFFF);
        text_q.push_back(16'h0000);
        send_text();

        // lone slash, line comment, "/*/" not closing, star run, escapes, slash on last
        text_q.delete();
        add_str("/(//}\n/*/(**/)\"\\\"{\"'\\''/");
        send_text();
        wait_drain();

        while (random_units < RANDOM_UNITS) begin
            gaps_on = ($urandom_range(0, 4) != 0);
            build_random_text();
            random_units += text_q.size();
            send_text();
            if ($urandom_range(0, 9) == 0) wait_drain();
        end

        wait_drain();
        repeat (10) @(posedge aclk);
        $display("Sent %0d texts (%0d code units); checked %0d beats,",
                 texts_sent, units_sent, board.checked);
        $display("%0d pairs, %0d with overflow, %0d mismatching or unexpected beats",
                 board.pairs, board.overflow_beats, board.errors);
        if (board.errors == 0 && board.predicted_beats.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
